>>> hw/rtl/lzo_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants for the layer z-order manager.
// No dependencies; lzo_if, the manager and the testbench import it.
package lzo_pkg;

  localparam int MAX_LAYERS_DEF = 256;

  localparam int KIND_W   = 1;
  localparam int LAYER_W  = 8;
  localparam int REQ_W    = 10;
  localparam int HEIGHT_W = 9;
  localparam int STATUS_W = 2;

  localparam logic [KIND_W-1:0] KIND_ALLOC = 1'b0;
  localparam logic [KIND_W-1:0] KIND_MOVE  = 1'b1;

  localparam logic signed [HEIGHT_W-1:0] HEIGHT_HIDDEN = -9'sd1;

  typedef enum logic [STATUS_W-1:0] {
    STATUS_OK       = 2'd0,
    STATUS_NO_SLOT  = 2'd1,
    STATUS_NOT_USED = 2'd2
  } lzo_status_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_LOOKUP,
    ST_SHIFT,
    ST_PLACE,
    ST_RESULT
  } lzo_state_e;

endpackage

>>> hw/rtl/lzo_if.sv
`timescale 1ns / 1ps
// Valid/ready stream interfaces for the request and result channels.
// Depends on lzo_pkg for field widths.
interface lzo_in_if;
  import lzo_pkg::*;
  logic                       valid;
  logic                       ready;
  logic [KIND_W-1:0]          kind;
  logic [LAYER_W-1:0]         layer_index;
  logic signed [REQ_W-1:0]    requested_height;

  modport source (output valid, kind, layer_index, requested_height, input ready);
  modport sink   (input valid, kind, layer_index, requested_height, output ready);
endinterface

interface lzo_out_if;
  import lzo_pkg::*;
  logic                       valid;
  logic                       ready;
  logic [STATUS_W-1:0]        status;
  logic [LAYER_W-1:0]         layer_out;
  logic signed [HEIGHT_W-1:0] height_out;
  logic signed [HEIGHT_W-1:0] top_out;

  modport source (output valid, status, layer_out, height_out, top_out, input ready);
  modport sink   (input valid, status, layer_out, height_out, top_out, output ready);
endinterface

>>> hw/rtl/lzo_ram.sv
`timescale 1ns / 1ps
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
module lzo_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256,
  localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

>>> hw/rtl/layer_z_order_manager.sv
`timescale 1ns / 1ps
// Layer z-order manager: slots are handed out lowest first and never freed, so slot
// use is a fill count. Layer heights and the stacking table live in two one-port-
// read RAMs. An allocate goes straight from accept to the result step; a move looks up
// its layer first, and a rejected move or one that keeps its height then goes to the
// result step, while any other move shifts the layers in between through the stacking
// table: the table RAM moves one entry per cycle through its single read and write
// port. A result may wait in the output register while the next item is accepted.
// Depends on lzo_pkg, lzo_if and lzo_ram.
module layer_z_order_manager #(
  parameter int MAX_LAYERS = lzo_pkg::MAX_LAYERS_DEF
) (
  input  logic clk_i,
  input  logic rst_ni,
  lzo_in_if.sink    in_i,
  lzo_out_if.source out_o
);
  import lzo_pkg::*;

  localparam int AW    = (MAX_LAYERS > 1) ? $clog2(MAX_LAYERS) : 1;
  localparam int CNT_W = $clog2(MAX_LAYERS + 1);
  localparam int CMP_W = (CNT_W > LAYER_W) ? CNT_W : LAYER_W;
  localparam int EXT_W = HEIGHT_W + 2;

  lzo_state_e state_q, state_d;

  logic [CNT_W-1:0]           count_q, count_d;
  logic signed [HEIGHT_W-1:0] top_q, top_d;
  logic [LAYER_W-1:0]         idx_q, idx_d;
  logic signed [REQ_W-1:0]    req_q, req_d;
  logic signed [HEIGHT_W-1:0] hh_q, hh_d;
  logic                       remove_q, remove_d;
  logic                       insert_q, insert_d;
  logic                       desc_q, desc_d;
  logic [AW-1:0]              p_q, p_d;
  logic [AW-1:0]              wpos_q, wpos_d;
  logic [HEIGHT_W-1:0]        n_q, n_d;
  logic                       pend_q, pend_d;

  lzo_status_e                res_status_q, res_status_d;
  logic [LAYER_W-1:0]         res_layer_q, res_layer_d;
  logic signed [HEIGHT_W-1:0] res_height_q, res_height_d;

  logic                       out_valid_q, out_valid_d;
  logic [STATUS_W-1:0]        out_status_q, out_status_d;
  logic [LAYER_W-1:0]         out_layer_q, out_layer_d;
  logic signed [HEIGHT_W-1:0] out_height_q, out_height_d;
  logic signed [HEIGHT_W-1:0] out_top_q, out_top_d;

  // RAM ports
  logic                       ord_we;
  logic [AW-1:0]              ord_waddr, ord_raddr;
  logic [LAYER_W-1:0]         ord_wdata, ord_rdata;
  logic                       hgt_we;
  logic [AW-1:0]              hgt_waddr, hgt_raddr;
  logic signed [HEIGHT_W-1:0] hgt_wdata, hgt_rdata;

  // clamp and case decode
  logic signed [EXT_W-1:0] old_x, req_x, top_x, lim_x, hh_x, start_x, n_x;
  logic                    in_acc, slot_ok, out_free;

  lzo_ram #(.WIDTH(LAYER_W), .DEPTH(MAX_LAYERS)) u_order_ram (
    .clk_i   (clk_i),
    .we_i    (ord_we),
    .waddr_i (ord_waddr),
    .wdata_i (ord_wdata),
    .raddr_i (ord_raddr),
    .rdata_o (ord_rdata)
  );

  lzo_ram #(.WIDTH(HEIGHT_W), .DEPTH(MAX_LAYERS)) u_height_ram (
    .clk_i   (clk_i),
    .we_i    (hgt_we),
    .waddr_i (hgt_waddr),
    .wdata_i (hgt_wdata),
    .raddr_i (hgt_raddr),
    .rdata_o (hgt_rdata)
  );

  assign in_i.ready = (state_q == ST_IDLE);
  assign in_acc     = in_i.valid && in_i.ready;
  assign out_free   = !out_valid_q || out_o.ready;
  assign slot_ok    = CMP_W'(idx_q) < CMP_W'(count_q);

  // height clamp: -1..top for a shown layer, -1..top+1 for a hidden one
  always_comb begin
    old_x = EXT_W'(hgt_rdata);
    req_x = EXT_W'(req_q);
    top_x = EXT_W'(top_q);
    lim_x = (old_x >= 0) ? top_x : top_x + EXT_W'(1);
    hh_x  = (req_x < -1) ? -EXT_W'(1) : req_x;
    if (hh_x > lim_x) begin
      hh_x = lim_x;
    end
  end

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (in_acc) begin
          state_d = (in_i.kind == KIND_MOVE) ? ST_LOOKUP : ST_RESULT;
        end
      end
      ST_LOOKUP: begin
        state_d = (slot_ok && (old_x != hh_x)) ? ST_SHIFT : ST_RESULT;
      end
      ST_SHIFT: begin
        if (n_q == '0) begin
          state_d = ST_PLACE;
        end
      end
      ST_PLACE:  state_d = ST_RESULT;
      ST_RESULT: begin
        if (out_free) begin
          state_d = ST_IDLE;
        end
      end
      default:   state_d = ST_IDLE;
    endcase
  end

  // datapath and RAM control
  always_comb begin
    count_d      = count_q;
    top_d        = top_q;
    idx_d        = idx_q;
    req_d        = req_q;
    hh_d         = hh_q;
    remove_d     = remove_q;
    insert_d     = insert_q;
    desc_d       = desc_q;
    p_d          = p_q;
    wpos_d       = wpos_q;
    n_d          = n_q;
    pend_d       = 1'b0;
    res_status_d = res_status_q;
    res_layer_d  = res_layer_q;
    res_height_d = res_height_q;
    out_valid_d  = out_valid_q && !out_o.ready;
    out_status_d = out_status_q;
    out_layer_d  = out_layer_q;
    out_height_d = out_height_q;
    out_top_d    = out_top_q;

    ord_we    = 1'b0;
    ord_waddr = p_q;
    ord_wdata = idx_q;
    ord_raddr = p_q;
    hgt_we    = 1'b0;
    hgt_waddr = AW'(idx_q);
    hgt_wdata = HEIGHT_HIDDEN;
    hgt_raddr = AW'(in_i.layer_index);

    start_x = '0;
    n_x     = '0;

    unique case (state_q)
      ST_IDLE: begin
        if (in_acc) begin
          idx_d = in_i.layer_index;
          req_d = in_i.requested_height;
          if (in_i.kind == KIND_ALLOC) begin
            res_height_d = HEIGHT_HIDDEN;
            if (count_q < CNT_W'(MAX_LAYERS)) begin
              hgt_we       = 1'b1;
              hgt_waddr    = AW'(count_q);
              count_d      = count_q + CNT_W'(1);
              res_status_d = STATUS_OK;
              res_layer_d  = LAYER_W'(count_q);
            end else begin
              res_status_d = STATUS_NO_SLOT;
              res_layer_d  = '0;
            end
          end
        end
      end
      ST_LOOKUP: begin
        res_layer_d = idx_q;
        if (!slot_ok) begin
          res_status_d = STATUS_NOT_USED;
          res_height_d = HEIGHT_HIDDEN;
        end else begin
          res_status_d = STATUS_OK;
          res_height_d = HEIGHT_W'(hh_x);
          hh_d         = HEIGHT_W'(hh_x);
          remove_d     = (old_x > hh_x) && (hh_x < 0);
          insert_d     = (old_x < hh_x) && (old_x < 0);
          if (old_x > hh_x) begin
            if (hh_x >= 0) begin
              // shown layer goes down: entries below it shift up
              desc_d  = 1'b1;
              start_x = old_x - EXT_W'(1);
              n_x     = old_x - hh_x;
            end else begin
              // leaves the stack: entries above it shift down
              desc_d  = 1'b0;
              start_x = old_x + EXT_W'(1);
              n_x     = top_x - old_x;
            end
          end else if (old_x >= 0) begin
            desc_d  = 1'b0;
            start_x = old_x + EXT_W'(1);
            n_x     = hh_x - old_x;
          end else begin
            // hidden layer enters: entries from hh up shift up by one
            desc_d  = 1'b1;
            start_x = top_x;
            n_x     = top_x - hh_x + EXT_W'(1);
          end
          p_d = AW'(start_x);
          n_d = HEIGHT_W'(n_x);
        end
      end
      ST_SHIFT: begin
        if (n_q != '0) begin
          ord_raddr = p_q;
          p_d       = desc_q ? p_q - AW'(1) : p_q + AW'(1);
          wpos_d    = desc_q ? p_q + AW'(1) : p_q - AW'(1);
          n_d       = n_q - HEIGHT_W'(1);
          pend_d    = 1'b1;
        end
        if (pend_q) begin
          ord_we    = 1'b1;
          ord_waddr = wpos_q;
          ord_wdata = ord_rdata;
          hgt_we    = 1'b1;
          hgt_waddr = AW'(ord_rdata);
          hgt_wdata = HEIGHT_W'(wpos_q);
        end
      end
      ST_PLACE: begin
        hgt_we    = 1'b1;
        hgt_waddr = AW'(idx_q);
        if (remove_q) begin
          hgt_wdata = HEIGHT_HIDDEN;
          top_d     = top_q - HEIGHT_W'(1);
        end else begin
          ord_we    = 1'b1;
          ord_waddr = AW'(unsigned'(hh_q));
          ord_wdata = idx_q;
          hgt_wdata = hh_q;
          if (insert_q) begin
            top_d = top_q + HEIGHT_W'(1);
          end
        end
      end
      ST_RESULT: begin
        if (out_free) begin
          out_valid_d  = 1'b1;
          out_status_d = res_status_q;
          out_layer_d  = res_layer_q;
          out_height_d = res_height_q;
          out_top_d    = top_q;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      count_q     <= '0;
      top_q       <= HEIGHT_HIDDEN;
      pend_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      top_q       <= top_d;
      pend_q      <= pend_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    idx_q        <= idx_d;
    req_q        <= req_d;
    hh_q         <= hh_d;
    remove_q     <= remove_d;
    insert_q     <= insert_d;
    desc_q       <= desc_d;
    p_q          <= p_d;
    wpos_q       <= wpos_d;
    n_q          <= n_d;
    res_status_q <= res_status_d;
    res_layer_q  <= res_layer_d;
    res_height_q <= res_height_d;
    out_status_q <= out_status_d;
    out_layer_q  <= out_layer_d;
    out_height_q <= out_height_d;
    out_top_q    <= out_top_d;
  end

  assign out_o.valid      = out_valid_q;
  assign out_o.status     = out_status_q;
  assign out_o.layer_out  = out_layer_q;
  assign out_o.height_out = out_height_q;
  assign out_o.top_out    = out_top_q;

  // stack never holds more layers than slots handed out
  a_top_below_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $signed(top_q) < $signed({1'b0, count_q}))
    else $error("top position at or above slot count");

  // shift stream never writes the entry it is reading in the same cycle
  a_shift_no_overlap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_SHIFT && pend_q && n_q != '0) |-> (ord_waddr != ord_raddr))
    else $error("stacking table read and write collide during shift");

  // top only moves in the place step, and by one
  a_top_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (top_q != $past(top_q)) |->
      ($past(state_q) == ST_PLACE &&
       (top_q == $past(top_q) + 9'sd1 || top_q == $past(top_q) - 9'sd1)))
    else $error("top position changed outside the place step");

  // an accepted item always leaves idle
  a_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_i.valid && in_i.ready) |=> (state_q != ST_IDLE))
    else $error("item accepted but sequencer stayed idle");

endmodule

>>> dv/layer_z_order_manager_tb.sv
`timescale 1ns / 1ps
// Self-checking testbench for layer_z_order_manager: drives allocate and move items,
// predicts the slot pool and stacking table, and checks every result in order.
// Depends on lzo_pkg, lzo_if and the RTL of layer_z_order_manager.
module layer_z_order_manager_tb;
  import lzo_pkg::*;

  localparam int NUM_SLOTS    = MAX_LAYERS_DEF;
  localparam int ITEMS_TOTAL  = 1450;
  localparam int DRAIN_AT     = 700;
  localparam int HOLDOFF_LEN  = 400;
  localparam int IDLE_LIMIT   = 4000;
  localparam int TAIL_CYCLES  = 300;
  localparam int ALLOC_PCT    = 28;

  typedef struct packed {
    lzo_status_e                status;
    logic [LAYER_W-1:0]         layer;
    logic signed [HEIGHT_W-1:0] height;
    logic signed [HEIGHT_W-1:0] top;
  } layer_result_t;

  // Slot pool and stacking table model plus the in-order store of expected results.
  class layer_stack_scoreboard;
    bit            slot_used[NUM_SLOTS];
    int            layer_h[NUM_SLOTS];
    int            stack_slot[NUM_SLOTS];
    int            top_pos;
    int            fill_count;
    int            accepted;
    int            error_count;
    layer_result_t expected_q[$];

    function new();
      foreach (slot_used[i]) begin
        slot_used[i]  = 1'b0;
        layer_h[i]    = 0;
        stack_slot[i] = 0;
      end
      top_pos     = -1;
      fill_count  = 0;
      accepted    = 0;
      error_count = 0;
    endfunction

    function int pending();
      return expected_q.size();
    endfunction

    function void put_at(int pos, int slot);
      stack_slot[pos] = slot;
      layer_h[slot]   = pos;
    endfunction

    function void note_request(logic [KIND_W-1:0] kind, logic [LAYER_W-1:0] idx,
                               logic signed [REQ_W-1:0] req);
      layer_result_t r;
      int            slot;
      int            old;
      int            hh;
      int            h;
      accepted++;
      slot     = idx;
      r.status = STATUS_OK;
      r.layer  = idx;
      r.height = HEIGHT_HIDDEN;
      if (kind == KIND_ALLOC) begin
        slot = -1;
        for (h = 0; h < NUM_SLOTS; h++) begin
          if (!slot_used[h]) begin
            slot = h;
            break;
          end
        end
        if (slot < 0) begin
          r.status = STATUS_NO_SLOT;
          r.layer  = '0;
        end else begin
          slot_used[slot] = 1'b1;
          layer_h[slot]   = -1;
          fill_count++;
          r.layer = LAYER_W'(slot);
        end
      end else if (!slot_used[slot]) begin
        r.status = STATUS_NOT_USED;
      end else begin
        old = layer_h[slot];
        hh  = req;
        if (hh < -1) hh = -1;
        // a shown layer cannot grow the stack, a hidden one may land just above the top
        if (old >= 0) begin
          if (hh > top_pos) hh = top_pos;
        end else if (hh > top_pos + 1) begin
          hh = top_pos + 1;
        end
        if (old > hh) begin
          if (hh >= 0) begin
            for (h = old; h > hh; h--) put_at(h, stack_slot[h-1]);
            put_at(hh, slot);
          end else begin
            for (h = old; h < top_pos; h++) put_at(h, stack_slot[h+1]);
            layer_h[slot] = -1;
            top_pos--;
          end
        end else if (old < hh) begin
          if (old >= 0) begin
            for (h = old; h < hh; h++) put_at(h, stack_slot[h+1]);
            put_at(hh, slot);
          end else begin
            for (h = top_pos; h >= hh; h--) put_at(h + 1, stack_slot[h]);
            put_at(hh, slot);
            top_pos++;
          end
        end
        r.height = HEIGHT_W'(layer_h[slot]);
      end
      r.top = HEIGHT_W'(top_pos);
      expected_q.push_back(r);
    endfunction

    task report_mismatch(string what, int got_v, int want_v);
      error_count++;
      $display("[%0t ns] mismatch on %s: got %0d, expected %0d", $time, what, got_v, want_v);
    endtask

    task check_result(layer_result_t got);
      layer_result_t want;
      if (expected_q.size() == 0) begin
        report_mismatch("result with no item pending, layer_out", got.layer, -1);
      end else begin
        want = expected_q.pop_front();
        if (got.status !== want.status)
          report_mismatch("status", got.status, want.status);
        if (got.layer !== want.layer)
          report_mismatch("layer_out", got.layer, want.layer);
        if (got.height !== want.height)
          report_mismatch("height_out", got.height, want.height);
        if (got.top !== want.top)
          report_mismatch("top_out", got.top, want.top);
      end
    endtask
  endclass

  logic clk_i = 1'b0;
  logic rst_ni;

  lzo_in_if  req_if ();
  lzo_out_if rsp_if ();

  layer_z_order_manager u_dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (req_if),
    .out_o  (rsp_if)
  );

  layer_stack_scoreboard sb = new();
  int items_sent = 0;

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  // Holds the fields until the item is taken, then notes it for prediction.
  task automatic send_item(logic [KIND_W-1:0] kind, logic [LAYER_W-1:0] idx,
                           logic signed [REQ_W-1:0] req);
    req_if.valid            <= 1'b1;
    req_if.kind             <= kind;
    req_if.layer_index      <= idx;
    req_if.requested_height <= req;
    do @(posedge clk_i); while (!req_if.ready);
    sb.note_request(kind, idx, req);
    items_sent++;
  endtask

  task automatic drain_results();
    req_if.valid <= 1'b0;
    do @(posedge clk_i); while (sb.pending() != 0);
  endtask

  task automatic send_random_item();
    logic [LAYER_W-1:0]      idx;
    logic signed [REQ_W-1:0] req;
    int                      pick;
    idx  = LAYER_W'($urandom);
    req  = REQ_W'($urandom);
    pick = $urandom_range(0, 99);
    if (pick < ALLOC_PCT) begin
      send_item(KIND_ALLOC, idx, req);
    end else begin
      // mostly target slots in use; the rest is noise on any index
      if (sb.fill_count > 0 && $urandom_range(0, 99) < 85)
        idx = LAYER_W'($urandom_range(0, sb.fill_count - 1));
      pick = $urandom_range(0, 99);
      if (pick < 40)
        req = REQ_W'(int'($urandom_range(0, sb.top_pos + 2)) - 1);
      else if (pick < 55)
        req = -10'sd1;
      else if (pick < 65)
        req = REQ_W'(sb.top_pos + $urandom_range(0, 1));
      else if (pick < 75)
        case ($urandom_range(0, 3))
          0: req = -10'sd512;
          1: req = 10'sd511;
          2: req = -10'sd2;
          default: req = 10'sd0;
        endcase
      send_item(KIND_MOVE, idx, req);
    end
  endtask

  initial begin
    int burst;
    int gap;
    int b;
    req_if.valid            <= 1'b0;
    req_if.kind             <= KIND_ALLOC;
    req_if.layer_index      <= '0;
    req_if.requested_height <= '0;
    rst_ni                  <= 1'b0;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: rejects, clamps at both ends, inserts, lifts, drops and removals
    send_item(KIND_MOVE,  8'd0,   10'sd0);
    send_item(KIND_MOVE,  8'd255, -10'sd1);
    send_item(KIND_ALLOC, 8'hff,  10'sd511);
    send_item(KIND_MOVE,  8'd0,   -10'sd512);
    send_item(KIND_MOVE,  8'd0,   10'sd511);
    send_item(KIND_MOVE,  8'd0,   10'sd0);
    send_item(KIND_ALLOC, 8'h00,  -10'sd512);
    send_item(KIND_ALLOC, 8'h5a,  10'sd0);
    send_item(KIND_MOVE,  8'd1,   10'sd0);
    send_item(KIND_MOVE,  8'd2,   10'sd511);
    send_item(KIND_MOVE,  8'd1,   10'sd511);
    send_item(KIND_MOVE,  8'd0,   10'sd1);
    send_item(KIND_MOVE,  8'd2,   -10'sd1);
    send_item(KIND_MOVE,  8'd1,   -10'sd2);
    send_item(KIND_MOVE,  8'd2,   -10'sd1);
    send_item(KIND_MOVE,  8'd3,   10'sd5);
    send_item(KIND_MOVE,  8'd0,   10'sd0);
    send_item(KIND_ALLOC, 8'ha5,  -10'sd1);
    send_item(KIND_MOVE,  8'd3,   10'sd0);
    send_item(KIND_MOVE,  8'd2,   10'sd1);
    send_item(KIND_MOVE,  8'd0,   -10'sd512);
    drain_results();

    while (items_sent < ITEMS_TOTAL) begin
      burst = ($urandom_range(0, 4) == 0) ? $urandom_range(20, 60) : $urandom_range(1, 12);
      for (b = 0; b < burst && items_sent < ITEMS_TOTAL; b++) begin
        if (items_sent == DRAIN_AT) drain_results();
        send_random_item();
      end
      gap = $urandom_range(1, 8);
      req_if.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end

    drain_results();
    repeat (TAIL_CYCLES) @(posedge clk_i);
    if (sb.error_count == 0 && sb.pending() == 0)
      $display("Testbench completed without errors");
    else
      $display("Testbench completed WITH ERRORS");
    $finish;
  end

  // Result side: segments of different stall patterns, plus long hold-offs that
  // back the block up into its input.
  initial begin
    int holdoff_at[2] = '{150, 1100};
    int holdoffs_done;
    int seg_len;
    int mode;
    int i;
    bit toggle;
    holdoffs_done = 0;
    toggle        = 1'b0;
    rsp_if.ready <= 1'b0;
    do @(posedge clk_i); while (!rst_ni);
    forever begin
      if (holdoffs_done < 2 && sb.accepted >= holdoff_at[holdoffs_done]) begin
        holdoffs_done++;
        rsp_if.ready <= 1'b0;
        repeat (HOLDOFF_LEN) @(posedge clk_i);
      end
      seg_len = $urandom_range(10, 150);
      mode    = $urandom_range(0, 3);
      for (i = 0; i < seg_len; i++) begin
        toggle = ~toggle;
        case (mode)
          0: rsp_if.ready <= 1'b1;
          1: rsp_if.ready <= ($urandom_range(0, 1) == 1);
          2: rsp_if.ready <= ($urandom_range(0, 3) == 0);
          default: rsp_if.ready <= toggle;
        endcase
        @(posedge clk_i);
      end
    end
  end

  always @(posedge clk_i) begin
    layer_result_t got;
    if (rst_ni && rsp_if.valid && rsp_if.ready) begin
      got.status = lzo_status_e'(rsp_if.status);
      got.layer  = rsp_if.layer_out;
      got.height = rsp_if.height_out;
      got.top    = rsp_if.top_out;
      sb.check_result(got);
    end
  end

  // Ends the run if neither channel moves an item for too long.
  initial begin
    int idle_cycles;
    idle_cycles = 0;
    while (idle_cycles < IDLE_LIMIT) begin
      @(posedge clk_i);
      if ((req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready))
        idle_cycles = 0;
      else
        idle_cycles++;
    end
    $display("[%0t ns] timeout: no item moved for %0d cycles", $time, IDLE_LIMIT);
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule
